// ----- rtl/core/bba_pkg.sv -----
// Shared constants, command codes and sizing helpers for the bitmap block allocator.
// No dependencies; every other file of the block imports this package.
package bba_pkg;

   // Command codes carried by req_command
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // Field widths fixed by the interface
   localparam int INDEX_W  = 12;
   localparam int COUNT_W  = 13;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register map: word index taken from paddr[2]
   localparam logic CSR_IDX_BLOCK_COUNT = 1'b0;

   // Defaults and byte constants
   localparam int              MAX_BLOCKS_DEF    = 4096;
   localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 13'd4096;
   localparam logic [7:0]      BYTE_FULL         = 8'hff;
   localparam logic [7:0]      BYTE_EMPTY        = 8'h00;
   localparam logic [7:0]      LEAD_BIT_MASK     = 8'h80;

   // Number of bitmap bytes for a block count
   function automatic int bm_depth(input int max_blocks);
      bm_depth = (max_blocks + 7) >> 3;
   endfunction

   // Byte address width, at least one bit
   function automatic int bm_addr_w(input int max_blocks);
      int d;
      d = (max_blocks + 7) >> 3;
      bm_addr_w = (d > 1) ? $clog2(d) : 1;
   endfunction

   // Width wide enough for block indexes, limits and the count register
   function automatic int bm_wide_w(input int max_blocks);
      int w;
      int a;
      w = $clog2(max_blocks + 1);
      a = bm_addr_w(max_blocks) + 3;
      if (a > w) begin
         w = a;
      end
      if (COUNT_W > w) begin
         w = COUNT_W;
      end
      bm_wide_w = w;
   endfunction

endpackage

// ----- rtl/core/bitmap_block_allocator_unit.sv -----
// Top level of the first-fit bitmap block allocator: register port, sequencer, bitmap memory.
// Depends on bba_pkg, bba_csr, bba_ctrl and bba_bitmap_ram.
//
//   channel   handshake                       payload
//   request   start, busy (taken: start&!busy) req_command, req_block_index
//   result    rsp_valid, one cycle, no stall  rsp_allocated_index, rsp_ok
//   config    psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// After reset the bitmap memory is cleared one byte a cycle, all (MAX_BLOCKS+7)/8 bytes
// (512 at the default), with busy high; register writes are taken during that pass.
// Allocate: the scan reads one bitmap byte a cycle through the single memory read port,
// from byte 0 up, until it meets a byte that is not full or the last byte below the limit.
// Release: byte read, then rewritten in the release state; an index at or above the limit
// is answered the cycle after the accept. One item at a time; busy drops with the result strobe.
module bitmap_block_allocator_unit
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_command,
   input  logic [INDEX_W-1:0]     req_block_index,
   output logic                   rsp_valid,
   output logic [INDEX_W-1:0]     rsp_allocated_index,
   output logic                   rsp_ok,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [CSR_ADDR_W-1:0]  paddr,
   input  logic [CSR_DATA_W-1:0]  pwdata,
   output logic [CSR_DATA_W-1:0]  prdata,
   output logic                   pready
);

   localparam int ADDR_W = bm_addr_w(MAX_BLOCKS);
   localparam int WIDE_W = bm_wide_w(MAX_BLOCKS);

   logic [WIDE_W-1:0] limit;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   // Register port and active limit
   bba_csr #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .limit   (limit)
   );

   // Command sequencer
   bba_ctrl #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_block_index     (req_block_index),
      .rsp_valid           (rsp_valid),
      .rsp_allocated_index (rsp_allocated_index),
      .rsp_ok              (rsp_ok),
      .limit               (limit),
      .wr_en               (wr_en),
      .wr_addr             (wr_addr),
      .wr_data             (wr_data),
      .rd_addr             (rd_addr),
      .rd_data             (rd_data)
   );

   // Bitmap storage
   bba_bitmap_ram #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// ----- rtl/core/bba_bitmap_ram.sv -----
// Bitmap byte memory: one write port, one read port with registered read data.
// Depends on bba_pkg for sizing helpers.
module bba_bitmap_ram
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [bm_addr_w(MAX_BLOCKS)-1:0]     wr_addr,
   input  logic [7:0]                           wr_data,
   input  logic [bm_addr_w(MAX_BLOCKS)-1:0]     rd_addr,
   output logic [7:0]                           rd_data
);

   localparam int DEPTH  = bm_depth(MAX_BLOCKS);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bba_csr.sv -----
// APB-style register port holding block_count, and the saturated active limit.
// Depends on bba_pkg for register map, reset value and sizing helpers.
module bba_csr
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [CSR_ADDR_W-1:0]             paddr,
   input  logic [CSR_DATA_W-1:0]             pwdata,
   output logic [CSR_DATA_W-1:0]             prdata,
   output logic                              pready,
   output logic [bm_wide_w(MAX_BLOCKS)-1:0]  limit
);

   localparam int WIDE_W = bm_wide_w(MAX_BLOCKS);

   logic [COUNT_W-1:0] block_count_ff;
   logic [COUNT_W-1:0] block_count_in;
   logic               wr_hit;
   logic [WIDE_W-1:0]  count_wide;
   logic [WIDE_W-1:0]  max_wide;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == CSR_IDX_BLOCK_COUNT);

   // Take the low bits of the write data
   always_comb begin
      block_count_in = block_count_ff;
      if (wr_hit) begin
         block_count_in = pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= BLOCK_COUNT_RST;
      end else begin
         block_count_ff <= block_count_in;
      end
   end

   // Read back
   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_BLOCK_COUNT) begin
         prdata = CSR_DATA_W'(block_count_ff);
      end
   end

   // Saturate the count at the bitmap size
   assign count_wide = WIDE_W'(block_count_ff);
   assign max_wide   = WIDE_W'(MAX_BLOCKS);
   assign limit      = (count_wide > max_wide) ? max_wide : count_wide;

endmodule

// ----- rtl/core/bba_ctrl.sv -----
// Sequencer: clearing pass after reset, first-fit byte scan, release read-modify-write.
// Depends on bba_pkg; drives the ports of bba_bitmap_ram.
module bba_ctrl
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_command,
   input  logic [INDEX_W-1:0]                req_block_index,
   output logic                              rsp_valid,
   output logic [INDEX_W-1:0]                rsp_allocated_index,
   output logic                              rsp_ok,
   input  logic [bm_wide_w(MAX_BLOCKS)-1:0]  limit,
   output logic                              wr_en,
   output logic [bm_addr_w(MAX_BLOCKS)-1:0]  wr_addr,
   output logic [7:0]                        wr_data,
   output logic [bm_addr_w(MAX_BLOCKS)-1:0]  rd_addr,
   input  logic [7:0]                        rd_data
);

   localparam int DEPTH  = bm_depth(MAX_BLOCKS);
   localparam int ADDR_W = bm_addr_w(MAX_BLOCKS);
   localparam int WIDE_W = bm_wide_w(MAX_BLOCKS);
   localparam int NB_W   = ADDR_W + 1;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_REL   = 2'd3;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [1:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   byte_ff, byte_in;
   logic [2:0]          bit_ff, bit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic                rsp_ok_ff, rsp_ok_in;

   logic                accept;
   logic [WIDE_W-1:0]   req_idx_wide;
   logic                req_in_range;
   logic [WIDE_W:0]     nbytes_sum;
   logic [NB_W-1:0]     nbytes;
   logic                cur_in_range;
   logic                next_in_range;
   logic                byte_full;
   logic [2:0]          free_bit;
   logic [WIDE_W-1:0]   found_idx;
   logic                found_ok;
   logic [7:0]          free_mask;
   logic [7:0]          rel_mask;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Release index decode
   assign req_idx_wide = WIDE_W'(req_block_index);
   assign req_in_range = (req_idx_wide < limit);

   // Bytes that hold blocks below the limit
   assign nbytes_sum    = (WIDE_W + 1)'(limit) + (WIDE_W + 1)'(7);
   assign nbytes        = NB_W'(nbytes_sum >> 3);
   assign cur_in_range  = (NB_W'(byte_ff) < nbytes);
   assign next_in_range = ((NB_W'(byte_ff) + NB_W'(1)) < nbytes);

   // First clear bit of the byte, lead bit first
   always_comb begin
      free_bit = 3'd0;
      for (int k = 7; k >= 0; k--) begin
         if (!rd_data[7 - k]) begin
            free_bit = 3'(k);
         end
      end
   end

   assign byte_full = (rd_data == BYTE_FULL);
   assign found_idx = WIDE_W'({byte_ff, free_bit});
   assign found_ok  = (found_idx < limit);
   assign free_mask = LEAD_BIT_MASK >> free_bit;
   assign rel_mask  = LEAD_BIT_MASK >> bit_ff;

   // Next state, memory ports and result
   always_comb begin
      state_in     = state_ff;
      byte_in      = byte_ff;
      bit_in       = bit_ff;
      rsp_valid_in = 1'b0;
      rsp_index_in = '0;
      rsp_ok_in    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = byte_ff;
      wr_data      = BYTE_EMPTY;
      rd_addr      = byte_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (byte_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
               byte_in  = '0;
            end else begin
               byte_in = byte_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_ALLOC) begin
                  rd_addr  = '0;
                  byte_in  = '0;
                  state_in = ST_SCAN;
               end else if (req_in_range) begin
                  rd_addr  = req_idx_wide[ADDR_W+2:3];
                  byte_in  = req_idx_wide[ADDR_W+2:3];
                  bit_in   = req_idx_wide[2:0];
                  state_in = ST_REL;
               end else begin
                  // out of range: drop and report not done
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            rd_addr = byte_ff + ADDR_W'(1);
            if (!cur_in_range) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else if (byte_full) begin
               if (next_in_range) begin
                  byte_in = byte_ff + ADDR_W'(1);
               end else begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (found_ok) begin
                  wr_en        = 1'b1;
                  wr_data      = rd_data | free_mask;
                  rsp_ok_in    = 1'b1;
                  rsp_index_in = INDEX_W'(found_idx);
               end
            end
         end
         ST_REL: begin
            wr_en        = 1'b1;
            wr_data      = rd_data & ~rel_mask;
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         byte_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         byte_ff      <= byte_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      bit_ff       <= bit_in;
      rsp_index_ff <= rsp_index_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_allocated_index = rsp_index_ff;
   assign rsp_ok              = rsp_ok_ff;

   // Every accepted item either answers next cycle or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff || busy))
      else $error("accepted item neither answered nor in progress");

   // A result only follows work in progress or an accept
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(busy || accept))
      else $error("result without an item");

   // Failed results carry a zero index
   a_fail_zero_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_index_ff == '0))
      else $error("failed result with nonzero index");

   // No memory write while idle
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff != ST_IDLE))
      else $error("bitmap write while idle");

   // Reset starts the clearing pass
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (state_ff == ST_CLEAR && byte_ff == '0))
      else $error("reset did not start clearing pass");

endmodule

// ----- tb/sv/tb_bitmap_block_allocator_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for bitmap_block_allocator_unit: first-fit allocate and release
// commands checked against a shadow bitmap. Depends on bba_pkg and the unit's RTL.
module tb_bitmap_block_allocator_unit
   import bba_pkg::*;
;

   localparam int SHADOW_BYTES   = (MAX_BLOCKS_DEF + 7) / 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [CSR_ADDR_W-1:0] BLOCK_COUNT_ADDR = {CSR_IDX_BLOCK_COUNT, 2'b00};

   typedef struct packed {
      logic               command;
      logic [INDEX_W-1:0] block_index;
   } alloc_cmd_type;

   typedef struct packed {
      logic [INDEX_W-1:0] allocated_index;
      logic               ok;
   } alloc_grant_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_command;
   logic [INDEX_W-1:0]    req_block_index;
   logic                  rsp_valid;
   logic [INDEX_W-1:0]    rsp_allocated_index;
   logic                  rsp_ok;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Shadow copy of the allocator state
   logic [7:0]            shadow_bitmap [0:SHADOW_BYTES-1];
   logic [COUNT_W-1:0]    shadow_block_count;

   alloc_cmd_type         pending_cmds [$];
   alloc_grant_type       awaited_grants [$];
   alloc_cmd_type         next_cmd;
   int unsigned           burst_left;
   int unsigned           gap_left;
   int unsigned           burst_count;
   bit                    hold_for_drain;
   int unsigned           quiet_cycles;
   int unsigned           error_count;

   bitmap_block_allocator_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_block_index     (req_block_index),
      .rsp_valid           (rsp_valid),
      .rsp_allocated_index (rsp_allocated_index),
      .rsp_ok              (rsp_ok),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Compute the grant for one command and update the shadow bitmap
   function automatic alloc_grant_type predict_grant(input logic command,
                                                     input logic [INDEX_W-1:0] block_index);
      alloc_grant_type grant;
      int unsigned     limit;
      int unsigned     pos;
      bit              found;
      grant = '0;
      found = 1'b0;
      limit = (shadow_block_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : shadow_block_count;
      if (command == CMD_ALLOC) begin
         for (int b = 0; b < (limit + 7) / 8 && !found; b++) begin
            if (shadow_bitmap[b] != BYTE_FULL) begin
               for (int k = 0; k < 8 && !found; k++) begin
                  pos = b * 8 + k;
                  // lowest index sits in the top bit of each byte
                  if (pos < limit && !shadow_bitmap[b][7-k]) begin
                     shadow_bitmap[b][7-k] = 1'b1;
                     grant.allocated_index = INDEX_W'(pos);
                     grant.ok = 1'b1;
                     found = 1'b1;
                  end
               end
            end
         end
      end else if (block_index < limit) begin
         shadow_bitmap[block_index / 8][7 - (block_index % 8)] = 1'b0;
         grant.ok = 1'b1;
      end
      return grant;
   endfunction

   // Driver: bursts of commands with random gaps, sometimes held until all grants are back
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            awaited_grants.push_back(predict_grant(req_command, req_block_index));
         end
         if (!start || !busy) begin
            if (gap_left != 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (hold_for_drain && awaited_grants.size() != 0) begin
               start <= 1'b0;
            end else if (pending_cmds.size() == 0) begin
               start <= 1'b0;
            end else begin
               hold_for_drain = 1'b0;
               next_cmd = pending_cmds.pop_front();
               start <= 1'b1;
               req_command <= next_cmd.command;
               req_block_index <= next_cmd.block_index;
               if (burst_left != 0) begin
                  burst_left--;
               end else begin
                  burst_count++;
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                  hold_for_drain = (burst_count == 1) || ($urandom_range(0, 9) == 0);
               end
            end
         end
      end
   end

   // Monitor: compare each grant with the oldest awaited one
   always @(posedge clock) begin
      alloc_grant_type want;
      if (!reset && rsp_valid) begin
         if (awaited_grants.size() == 0) begin
            $error("grant with no command outstanding: allocated_index %0d ok %0b",
                   rsp_allocated_index, rsp_ok);
            error_count++;
         end else begin
            want = awaited_grants.pop_front();
            if (rsp_allocated_index !== want.allocated_index) begin
               $error("allocated_index: expected %0d, got %0d",
                      want.allocated_index, rsp_allocated_index);
               error_count++;
            end
            if (rsp_ok !== want.ok) begin
               $error("ok: expected %0b, got %0b", want.ok, rsp_ok);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run after a long stretch with no traffic at all
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("[bitmap_block_allocator_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_cmd(input logic command, input logic [INDEX_W-1:0] block_index);
      alloc_cmd_type c;
      c.command = command;
      c.block_index = block_index;
      pending_cmds.push_back(c);
   endtask

   // Wait until no command is queued, on the bus or awaiting its grant
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || start || awaited_grants.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // Drain, then write block_count through a setup and an access phase
   task automatic write_block_count(input logic [CSR_DATA_W-1:0] value);
      wait_idle();
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= BLOCK_COUNT_ADDR;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      shadow_block_count = value[COUNT_W-1:0];
      @(negedge clock);
   endtask

   // Queue random commands, releases mostly aimed near the low end of the bitmap
   task automatic queue_random_cmds(input int unsigned n_items);
      int unsigned        limit;
      int unsigned        span;
      int unsigned        alloc_pct;
      logic [INDEX_W-1:0] idx;
      limit = (shadow_block_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : shadow_block_count;
      span = (limit < 300) ? limit + 1 : 300;
      alloc_pct = $urandom_range(35, 75);
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            idx = INDEX_W'($urandom);
         end else begin
            idx = INDEX_W'($urandom_range(0, span));
         end
         if ($urandom_range(1, 100) <= alloc_pct) begin
            queue_cmd(CMD_ALLOC, INDEX_W'($urandom));
         end else begin
            queue_cmd(CMD_RELEASE, idx);
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_ALLOC;
      req_block_index = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      burst_left = 0;
      gap_left = 0;
      burst_count = 0;
      hold_for_drain = 1'b0;
      quiet_cycles = 0;
      error_count = 0;
      shadow_block_count = BLOCK_COUNT_RST;
      for (int b = 0; b < SHADOW_BYTES; b++) begin
         shadow_bitmap[b] = BYTE_EMPTY;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset count: basic allocate, release, top index, release of a free block
      queue_cmd(CMD_ALLOC, '0);
      queue_cmd(CMD_ALLOC, '0);
      queue_cmd(CMD_RELEASE, 12'd0);
      queue_cmd(CMD_ALLOC, '0);
      queue_cmd(CMD_RELEASE, 12'd4095);
      queue_cmd(CMD_ALLOC, '1);
      queue_cmd(CMD_RELEASE, 12'd1);

      // Zero blocks: allocate fails, release ignored
      write_block_count(32'd0);
      queue_cmd(CMD_ALLOC, '0);
      queue_cmd(CMD_RELEASE, 12'd0);

      // Count above the maximum saturates
      write_block_count(32'd8191);
      queue_cmd(CMD_RELEASE, 12'd4095);
      queue_cmd(CMD_ALLOC, '0);

      // Ten blocks: fill up, hit a partly used byte with nothing usable, release past the end
      write_block_count(32'd10);
      repeat (8) queue_cmd(CMD_ALLOC, '0);
      queue_cmd(CMD_RELEASE, 12'd10);
      queue_cmd(CMD_RELEASE, 12'd9);
      queue_cmd(CMD_ALLOC, '0);
      queue_cmd(CMD_ALLOC, '0);

      // Random phases over a spread of block counts
      write_block_count(32'd8);
      queue_random_cmds(90);
      write_block_count(32'd1);
      queue_random_cmds(60);
      write_block_count(32'd64);
      queue_random_cmds(120);
      write_block_count(32'd9);
      queue_random_cmds(80);
      write_block_count(32'd4096);
      queue_random_cmds(150);
      write_block_count(32'd0);
      queue_random_cmds(30);
      write_block_count(32'd200);
      queue_random_cmds(100);
      write_block_count(32'd8191);
      queue_random_cmds(60);
      write_block_count(32'd4095);
      queue_random_cmds(110);
      write_block_count(32'd15);
      queue_random_cmds(80);
      // upper data bits fall outside the register
      write_block_count(($urandom & ~32'h1fff) | 32'd33);
      queue_random_cmds(90);
      write_block_count(32'($urandom_range(1, 4096)));
      queue_random_cmds(100);
      write_block_count(32'd16);
      queue_random_cmds(60);

      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("[bitmap_block_allocator_unit] OK");
      end else begin
         $display("[bitmap_block_allocator_unit] ERROR");
      end
      $finish;
   end

endmodule
